### src/orthonormalise_3x3_basis_macros.svh
// Assertion macros for the orthonormalisation RTL, included by its top level.
// Holds nothing but macro definitions and needs no other file.
`ifndef ORTHONORMALISE_3X3_BASIS_MACROS_SVH
`define ORTHONORMALISE_3X3_BASIS_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ORTH3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define ORTH3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/orth3_pkg.sv
// Shared constants and control structs for the orthonormalisation block.
// Used by orth3_lane, orth3_merge and orthonormalise_3x3_basis; depends on nothing.
package orth3_pkg;

  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 30;
  // Headroom above the element width for residual vectors and dot products.
  localparam int unsigned GUARD_BITS     = 4;
  localparam int unsigned NUM_LANES      = 3;

  typedef struct packed {
    logic mul_en;
    logic mul_sq;
    logic t_load;
    logic div_start;
  } lane_cmd_t;

  typedef struct packed {
    logic k_load;
    logic sq_start;
  } merge_cmd_t;

endpackage

### src/orth3_lane.sv
// One component lane: magnitude, scaling shift, multiplier, rounding subtract
// and a one-bit-per-cycle divider for the normalised output. Uses orth3_pkg.
module orth3_lane #(
  parameter int unsigned ELEM_WIDTH = orth3_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = orth3_pkg::FRAC_BITS_DEF
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  orth3_pkg::lane_cmd_t                                    cmd_i,
  input  logic [$clog2(orth3_pkg::GUARD_BITS + 2)-1:0]            k_i,
  input  logic signed [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]      a_i,
  input  logic signed [ELEM_WIDTH-1:0]                            b_i,
  input  logic signed [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]      base_i,
  input  logic [ELEM_WIDTH-1:0]                                   root_i,
  output logic [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]             mag_o,
  output logic signed [2*ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]    prod_o,
  output logic signed [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]      sub_o,
  output logic signed [ELEM_WIDTH-1:0]                            unit_o,
  output logic                                                    div_busy_o
);

  localparam int unsigned VW = ELEM_WIDTH + orth3_pkg::GUARD_BITS;
  localparam int unsigned PW = VW + ELEM_WIDTH;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = ELEM_WIDTH + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned SW = ((QW + 1 > ELEM_WIDTH) ? QW + 1 : ELEM_WIDTH) + 1;
  localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic signed [VW-1:0]         a_shift;
  logic signed [ELEM_WIDTH-1:0] t_q;
  logic signed [VW-1:0]         op_a;
  logic signed [ELEM_WIDTH-1:0] op_b;
  logic signed [PW-1:0]         prod_q;
  logic signed [PW:0]           prnd;
  logic signed [PW:0]           prnd_sh;
  logic                         t_neg;
  logic [ELEM_WIDTH-1:0]        t_mag;
  logic [NW-1:0]                numer;
  logic [ELEM_WIDTH-1:0]        rem_q;
  logic [QW-1:0]                dvd_q;
  logic [QW-1:0]                quo_q;
  logic [CW-1:0]                cnt_q;
  logic [ELEM_WIDTH:0]          rem_sh;
  logic                         q_bit;
  logic signed [SW-1:0]         q_s;
  logic signed [SW-1:0]         q_val;
  logic signed [SW-1:0]         max_v;
  logic signed [SW-1:0]         min_v;

  assign mag_o   = a_i[VW-1] ? VW'(-a_i) : VW'(a_i);
  assign a_shift = a_i >>> k_i;

  always_comb begin
    op_a = cmd_i.mul_sq ? VW'(t_q) : a_i;
    op_b = cmd_i.mul_sq ? t_q : b_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_load) begin
      t_q <= a_shift[ELEM_WIDTH-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
  end

  assign prod_o = prod_q;

  // Rounded product, half an LSB up and then floored.
  always_comb begin
    prnd    = (PW + 1)'(prod_q) + HALF;
    prnd_sh = prnd >>> FRAC_BITS;
    sub_o   = base_i - $signed(prnd_sh[VW-1:0]);
  end

  // The quotient never exceeds 2^FRAC_BITS because |t| is at most the root,
  // so FRAC_BITS+1 quotient bits cover it.
  assign t_neg  = t_q[ELEM_WIDTH-1];
  assign t_mag  = t_neg ? ELEM_WIDTH'(-t_q) : ELEM_WIDTH'(t_q);
  assign numer  = NW'({t_mag, {FRAC_BITS{1'b0}}}) + NW'(root_i >> 1);
  assign rem_sh = {rem_q, dvd_q[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, root_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CW'(QW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= numer[NW-1:QW];
      dvd_q <= numer[QW-1:0];
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= q_bit ? ELEM_WIDTH'(rem_sh - {1'b0, root_i}) : rem_sh[ELEM_WIDTH-1:0];
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
  end

  assign div_busy_o = (cnt_q != '0);

  always_comb begin
    max_v = {{(SW - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
    min_v = {{(SW - ELEM_WIDTH + 1){1'b1}}, {(ELEM_WIDTH - 1){1'b0}}};
    q_s   = SW'(quo_q);
    q_val = t_neg ? -q_s : q_s;
    if (q_val > max_v) begin
      unit_o = max_v[ELEM_WIDTH-1:0];
    end else if (q_val < min_v) begin
      unit_o = min_v[ELEM_WIDTH-1:0];
    end else begin
      unit_o = q_val[ELEM_WIDTH-1:0];
    end
  end

endmodule

### src/orth3_merge.sv
// Merging stage across the three lanes: largest magnitude and scaling shift,
// rounded dot product, sum of squares and a bit-serial square root. Uses orth3_pkg.
module orth3_merge #(
  parameter int unsigned ELEM_WIDTH = orth3_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = orth3_pkg::FRAC_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  orth3_pkg::merge_cmd_t                                cmd_i,
  input  logic [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]          mag_i  [orth3_pkg::NUM_LANES],
  input  logic signed [2*ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0] prod_i [orth3_pkg::NUM_LANES],
  output logic [$clog2(orth3_pkg::GUARD_BITS + 2)-1:0]         k_o,
  output logic signed [ELEM_WIDTH+orth3_pkg::GUARD_BITS-1:0]   dot_o,
  output logic [ELEM_WIDTH-1:0]                                root_o,
  output logic                                                 sqrt_busy_o,
  output logic                                                 s_zero_o
);

  localparam int unsigned VW   = ELEM_WIDTH + orth3_pkg::GUARD_BITS;
  localparam int unsigned PW   = VW + ELEM_WIDTH;
  localparam int unsigned KMAX = orth3_pkg::GUARD_BITS + 1;
  localparam int unsigned KW   = $clog2(orth3_pkg::GUARD_BITS + 2);
  localparam int unsigned SCW  = $clog2(ELEM_WIDTH + 1);
  localparam logic [VW-1:0] THRESH = VW'(1) << (ELEM_WIDTH - 1);
  localparam logic signed [PW+1:0] HALF = (PW + 2)'(1) << (FRAC_BITS - 1);

  logic [VW-1:0]             mx;
  logic [KW-1:0]             k_d;
  logic [KW-1:0]             k_q;
  logic signed [PW+1:0]      psum;
  logic signed [PW+1:0]      prnd_sh;
  logic [2*ELEM_WIDTH-1:0]   s_d;
  logic [2*ELEM_WIDTH-1:0]   sh_q;
  logic [ELEM_WIDTH+1:0]     rem_q;
  logic [ELEM_WIDTH-1:0]     root_q;
  logic [SCW-1:0]            cnt_q;
  logic                      s_zero_q;
  logic [ELEM_WIDTH+1:0]     rem2;
  logic [ELEM_WIDTH+1:0]     trial;

  // Smallest shift that brings the largest magnitude into the element range.
  always_comb begin
    mx = mag_i[0];
    if (mag_i[1] > mx) begin
      mx = mag_i[1];
    end
    if (mag_i[2] > mx) begin
      mx = mag_i[2];
    end
    k_d = '0;
    for (int j = 0; j < KMAX; j++) begin
      if ((mx >> j) >= THRESH) begin
        k_d = KW'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.k_load) begin
      k_q <= k_d;
    end
  end

  assign k_o = k_q;

  always_comb begin
    psum    = (PW + 2)'(prod_i[0]) + (PW + 2)'(prod_i[1]) + (PW + 2)'(prod_i[2]);
    prnd_sh = (psum + HALF) >>> FRAC_BITS;
    dot_o   = $signed(prnd_sh[VW-1:0]);
    s_d     = psum[2*ELEM_WIDTH-1:0];
  end

  // Square root, one result bit per cycle from the top pair of bits down.
  assign rem2  = {rem_q[ELEM_WIDTH-1:0], sh_q[2*ELEM_WIDTH-1 -: 2]};
  assign trial = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sq_start) begin
      cnt_q <= SCW'(ELEM_WIDTH);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - SCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      sh_q     <= s_d;
      rem_q    <= '0;
      root_q   <= '0;
      s_zero_q <= (s_d == '0);
    end else if (cnt_q != '0) begin
      sh_q <= sh_q << 2;
      if (rem2 >= trial) begin
        rem_q  <= rem2 - trial;
        root_q <= {root_q[ELEM_WIDTH-2:0], 1'b1};
      end else begin
        rem_q  <= rem2;
        root_q <= {root_q[ELEM_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign root_o      = root_q;
  assign sqrt_busy_o = (cnt_q != '0);
  assign s_zero_o    = s_zero_q;

endmodule

### src/orthonormalise_3x3_basis.sv
// Gram-Schmidt orthonormalisation of a 3x3 basis in signed fixed point. The y axis is
// normalised, then z with its y part removed, then x with its y and z parts removed; an
// axis of zero length comes out as zeros and raises degenerate. Three component lanes work
// side by side, each with a multiplier and a divider, feeding a merging stage that holds the
// square-root unit. The time for one matrix is set by the square root (one result bit a cycle)
// and the lane dividers (one quotient bit a cycle), run once per axis; a zero-length axis
// skips its division. A new beat is taken into an input buffer while the previous matrix is
// being worked on, and the finished result waits in an output register. Depends on orth3_pkg,
// orth3_lane, orth3_merge and orthonormalise_3x3_basis_macros.svh.
module orthonormalise_3x3_basis #(
  parameter int unsigned ELEM_WIDTH = orth3_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = orth3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ELEM_WIDTH-1:0] in_xaxis_x_i,
  input  logic signed [ELEM_WIDTH-1:0] in_xaxis_y_i,
  input  logic signed [ELEM_WIDTH-1:0] in_xaxis_z_i,
  input  logic signed [ELEM_WIDTH-1:0] in_yaxis_x_i,
  input  logic signed [ELEM_WIDTH-1:0] in_yaxis_y_i,
  input  logic signed [ELEM_WIDTH-1:0] in_yaxis_z_i,
  input  logic signed [ELEM_WIDTH-1:0] in_zaxis_x_i,
  input  logic signed [ELEM_WIDTH-1:0] in_zaxis_y_i,
  input  logic signed [ELEM_WIDTH-1:0] in_zaxis_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ELEM_WIDTH-1:0] out_xaxis_x_o,
  output logic signed [ELEM_WIDTH-1:0] out_xaxis_y_o,
  output logic signed [ELEM_WIDTH-1:0] out_xaxis_z_o,
  output logic signed [ELEM_WIDTH-1:0] out_yaxis_x_o,
  output logic signed [ELEM_WIDTH-1:0] out_yaxis_y_o,
  output logic signed [ELEM_WIDTH-1:0] out_yaxis_z_o,
  output logic signed [ELEM_WIDTH-1:0] out_zaxis_x_o,
  output logic signed [ELEM_WIDTH-1:0] out_zaxis_y_o,
  output logic signed [ELEM_WIDTH-1:0] out_zaxis_z_o,
  output logic                         degenerate_o
);

  `include "orthonormalise_3x3_basis_macros.svh"

  localparam int unsigned NL = orth3_pkg::NUM_LANES;
  localparam int unsigned VW = ELEM_WIDTH + orth3_pkg::GUARD_BITS;
  localparam int unsigned PW = VW + ELEM_WIDTH;
  localparam int unsigned KW = $clog2(orth3_pkg::GUARD_BITS + 2);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_NMAX   = 13'b0000000000010,
    S_NSHIFT = 13'b0000000000100,
    S_NSQ    = 13'b0000000001000,
    S_NSUM   = 13'b0000000010000,
    S_NSQRT  = 13'b0000000100000,
    S_NDIV   = 13'b0000001000000,
    S_DMUL   = 13'b0000010000000,
    S_DSUM   = 13'b0000100000000,
    S_SMUL   = 13'b0001000000000,
    S_SSUB   = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_e;

  // Which step of the orthonormalisation the current operation belongs to.
  typedef enum logic [8:0] {
    P_NY  = 9'b000000001,
    P_DZ  = 9'b000000010,
    P_SZ  = 9'b000000100,
    P_NZ  = 9'b000001000,
    P_DXY = 9'b000010000,
    P_DXZ = 9'b000100000,
    P_SXY = 9'b001000000,
    P_SXZ = 9'b010000000,
    P_NX  = 9'b100000000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic                         inbuf_valid_q;
  logic signed [ELEM_WIDTH-1:0] bx_q [NL];
  logic signed [ELEM_WIDTH-1:0] by_q [NL];
  logic signed [ELEM_WIDTH-1:0] bz_q [NL];

  logic signed [VW-1:0]         x_q  [NL];
  logic signed [VW-1:0]         y_q  [NL];
  logic signed [VW-1:0]         z_q  [NL];
  logic signed [VW-1:0]         r_q  [NL];
  logic signed [ELEM_WIDTH-1:0] uy_q [NL];
  logic signed [ELEM_WIDTH-1:0] uz_q [NL];
  logic signed [ELEM_WIDTH-1:0] ux_q [NL];
  logic signed [VW-1:0]         dot_a_q;
  logic signed [VW-1:0]         dot_b_q;
  logic                         deg_q;

  logic                         out_valid_q;
  logic signed [ELEM_WIDTH-1:0] ox_q [NL];
  logic signed [ELEM_WIDTH-1:0] oy_q [NL];
  logic signed [ELEM_WIDTH-1:0] oz_q [NL];
  logic                         odeg_q;

  orth3_pkg::lane_cmd_t         lane_cmd;
  orth3_pkg::merge_cmd_t        merge_cmd;
  logic signed [VW-1:0]         lane_a    [NL];
  logic signed [ELEM_WIDTH-1:0] lane_b    [NL];
  logic signed [VW-1:0]         lane_base [NL];
  logic [VW-1:0]                lane_mag  [NL];
  logic signed [PW-1:0]         lane_prod [NL];
  logic signed [VW-1:0]         lane_sub  [NL];
  logic signed [ELEM_WIDTH-1:0] lane_unit [NL];
  logic [NL-1:0]                lane_busy;
  logic [KW-1:0]                k;
  logic signed [VW-1:0]         dot;
  logic [ELEM_WIDTH-1:0]        root;
  logic                         sqrt_busy;
  logic                         s_zero;

  logic take_item;
  logic wr_unit;
  logic wr_zero;
  logic wr_dot;
  logic wr_sub;
  logic out_load;

  assign in_ready_o = !inbuf_valid_q;

  // Operand selection for the lanes.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_b[i] = (phase_q == P_DXZ || phase_q == P_SXZ) ? uz_q[i] : uy_q[i];
      case (phase_q)
        P_SZ:    lane_base[i] = z_q[i];
        P_SXY:   lane_base[i] = x_q[i];
        default: lane_base[i] = r_q[i];
      endcase
      case (state_q)
        S_DMUL:  lane_a[i] = (phase_q == P_DZ) ? z_q[i] : x_q[i];
        S_SMUL:  lane_a[i] = (phase_q == P_SXZ) ? dot_b_q : dot_a_q;
        default: lane_a[i] = (phase_q == P_NY) ? y_q[i] : r_q[i];
      endcase
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    orth3_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (lane_cmd),
      .k_i        (k),
      .a_i        (lane_a[g]),
      .b_i        (lane_b[g]),
      .base_i     (lane_base[g]),
      .root_i     (root),
      .mag_o      (lane_mag[g]),
      .prod_o     (lane_prod[g]),
      .sub_o      (lane_sub[g]),
      .unit_o     (lane_unit[g]),
      .div_busy_o (lane_busy[g])
    );
  end

  orth3_merge #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (merge_cmd),
    .mag_i       (lane_mag),
    .prod_i      (lane_prod),
    .k_o         (k),
    .dot_o       (dot),
    .root_o      (root),
    .sqrt_busy_o (sqrt_busy),
    .s_zero_o    (s_zero)
  );

  // Sequencer: three normalisations with the dot products and subtractions between them.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    lane_cmd  = '0;
    merge_cmd = '0;
    take_item = 1'b0;
    wr_unit   = 1'b0;
    wr_zero   = 1'b0;
    wr_dot    = 1'b0;
    wr_sub    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (inbuf_valid_q) begin
          take_item = 1'b1;
          state_d   = S_NMAX;
          phase_d   = P_NY;
        end
      end
      S_NMAX: begin
        merge_cmd.k_load = 1'b1;
        state_d          = S_NSHIFT;
      end
      S_NSHIFT: begin
        lane_cmd.t_load = 1'b1;
        state_d         = S_NSQ;
      end
      S_NSQ: begin
        lane_cmd.mul_en = 1'b1;
        lane_cmd.mul_sq = 1'b1;
        state_d         = S_NSUM;
      end
      S_NSUM: begin
        merge_cmd.sq_start = 1'b1;
        state_d            = S_NSQRT;
      end
      S_NSQRT, S_NDIV: begin
        if (state_q == S_NSQRT && !sqrt_busy && !s_zero) begin
          lane_cmd.div_start = 1'b1;
          state_d            = S_NDIV;
        end else if ((state_q == S_NSQRT && !sqrt_busy) ||
                     (state_q == S_NDIV && lane_busy == '0)) begin
          wr_zero = (state_q == S_NSQRT);
          wr_unit = (state_q == S_NDIV);
          case (phase_q)
            P_NY: begin
              state_d = S_DMUL;
              phase_d = P_DZ;
            end
            P_NZ: begin
              state_d = S_DMUL;
              phase_d = P_DXY;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DMUL: begin
        lane_cmd.mul_en = 1'b1;
        state_d         = S_DSUM;
      end
      S_DSUM: begin
        wr_dot = 1'b1;
        case (phase_q)
          P_DZ: begin
            state_d = S_SMUL;
            phase_d = P_SZ;
          end
          P_DXY: begin
            state_d = S_DMUL;
            phase_d = P_DXZ;
          end
          default: begin
            state_d = S_SMUL;
            phase_d = P_SXY;
          end
        endcase
      end
      S_SMUL: begin
        lane_cmd.mul_en = 1'b1;
        state_d         = S_SSUB;
      end
      S_SSUB: begin
        wr_sub = 1'b1;
        case (phase_q)
          P_SZ: begin
            state_d = S_NMAX;
            phase_d = P_NZ;
          end
          P_SXY: begin
            state_d = S_SMUL;
            phase_d = P_SXZ;
          end
          default: begin
            state_d = S_NMAX;
            phase_d = P_NX;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= P_NY;
      inbuf_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      deg_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (in_valid_i && in_ready_o) begin
        inbuf_valid_q <= 1'b1;
      end else if (take_item) begin
        inbuf_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take_item) begin
        deg_q <= 1'b0;
      end else if (wr_zero) begin
        deg_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      bx_q[0] <= in_xaxis_x_i;
      bx_q[1] <= in_xaxis_y_i;
      bx_q[2] <= in_xaxis_z_i;
      by_q[0] <= in_yaxis_x_i;
      by_q[1] <= in_yaxis_y_i;
      by_q[2] <= in_yaxis_z_i;
      bz_q[0] <= in_zaxis_x_i;
      bz_q[1] <= in_zaxis_y_i;
      bz_q[2] <= in_zaxis_z_i;
    end
    for (int i = 0; i < NL; i++) begin
      if (take_item) begin
        x_q[i] <= VW'(bx_q[i]);
        y_q[i] <= VW'(by_q[i]);
        z_q[i] <= VW'(bz_q[i]);
      end
      if (wr_sub) begin
        r_q[i] <= lane_sub[i];
      end
      if (wr_unit || wr_zero) begin
        case (phase_q)
          P_NY:    uy_q[i] <= wr_zero ? '0 : lane_unit[i];
          P_NZ:    uz_q[i] <= wr_zero ? '0 : lane_unit[i];
          default: ux_q[i] <= wr_zero ? '0 : lane_unit[i];
        endcase
      end
      if (out_load) begin
        ox_q[i] <= ux_q[i];
        oy_q[i] <= uy_q[i];
        oz_q[i] <= uz_q[i];
      end
    end
    if (wr_dot) begin
      if (phase_q == P_DXZ) begin
        dot_b_q <= dot;
      end else begin
        dot_a_q <= dot;
      end
    end
    if (out_load) begin
      odeg_q <= deg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_xaxis_x_o = ox_q[0];
  assign out_xaxis_y_o = ox_q[1];
  assign out_xaxis_z_o = ox_q[2];
  assign out_yaxis_x_o = oy_q[0];
  assign out_yaxis_y_o = oy_q[1];
  assign out_yaxis_z_o = oy_q[2];
  assign out_zaxis_x_o = oz_q[0];
  assign out_zaxis_y_o = oz_q[1];
  assign out_zaxis_z_o = oz_q[2];
  assign degenerate_o  = odeg_q;

  // The three dividers always start together and so must finish together.
  `ORTH3_ASSERT_IMP(a_lanes_lockstep, clk_i, rst_ni, lane_busy[0],
                    lane_busy[1] && lane_busy[2], "lane dividers out of step")

  // A zero sum of squares marks the matrix as degenerate.
  `ORTH3_ASSERT_NXT(a_zero_sets_deg, clk_i, rst_ni,
                    state_q == S_NSQRT && !sqrt_busy && s_zero, deg_q,
                    "zero-length axis did not set degenerate")

  // A buffered matrix starts with the y axis.
  `ORTH3_ASSERT_NXT(a_start_on_y, clk_i, rst_ni, state_q == S_IDLE && inbuf_valid_q,
                    state_q == S_NMAX && phase_q == P_NY, "new matrix did not start with y")

  // A finished result is held back while the previous one is still waiting.
  `ORTH3_ASSERT_NXT(a_done_holds, clk_i, rst_ni,
                    state_q == S_DONE && out_valid_q && !out_ready_i, state_q == S_DONE,
                    "result overwrote a pending beat")

  // The dividers only run during the division step.
  `ORTH3_ASSERT_IMP(a_div_in_step, clk_i, rst_ni, lane_busy[0], state_q == S_NDIV,
                    "divider busy outside division")

endmodule

### test/tb_orthonormalise_3x3_basis.sv
// Self-checking testbench for orthonormalise_3x3_basis: directed table then random matrices,
// checked beat by beat against a fixed-point Gram-Schmidt predictor held here or, for typed
// rows, a stored result. Depends on the RTL top level and on orth3_pkg.
module tb_orthonormalise_3x3_basis;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = orth3_pkg::ELEM_WIDTH_DEF;
  localparam int FB = orth3_pkg::FRAC_BITS_DEF;
  localparam longint EMAX = (64'sd1 <<< (EW - 1)) - 1;
  localparam longint EMIN = -(64'sd1 <<< (EW - 1));
  localparam longint HALF = 64'sd1 <<< (FB - 1);
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int N_RANDOM = 900;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2500;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct {
    elem_t e[9];
    logic  deg;
  } basis_t;
  typedef struct {
    elem_t  e[9];
    bit     typed;
    basis_t want;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, degenerate_o;
  elem_t in_e[9];
  elem_t out_e[9];

  orthonormalise_3x3_basis u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .in_xaxis_x_i(in_e[0]), .in_xaxis_y_i(in_e[1]), .in_xaxis_z_i(in_e[2]),
    .in_yaxis_x_i(in_e[3]), .in_yaxis_y_i(in_e[4]), .in_yaxis_z_i(in_e[5]),
    .in_zaxis_x_i(in_e[6]), .in_zaxis_y_i(in_e[7]), .in_zaxis_z_i(in_e[8]),
    .out_valid_o, .out_ready_i,
    .out_xaxis_x_o(out_e[0]), .out_xaxis_y_o(out_e[1]), .out_xaxis_z_o(out_e[2]),
    .out_yaxis_x_o(out_e[3]), .out_yaxis_y_o(out_e[4]), .out_yaxis_z_o(out_e[5]),
    .out_zaxis_x_o(out_e[6]), .out_zaxis_y_o(out_e[7]), .out_zaxis_z_o(out_e[8]),
    .degenerate_o
  );

  basis_t expected_bases[$];
  bit     cur_typed;
  basis_t cur_want;
  logic   in_fire;
  int     errors = 0;
  int     beats_in = 0, beats_out = 0, degenerate_seen = 0;
  int     send_idle_pct = 0, recv_stall_pct = 0;
  int     hold_seq = 0;
  int     idle_cycles = 0;

  const string FIELD_NAMES[10] = '{"xaxis_x", "xaxis_y", "xaxis_z", "yaxis_x", "yaxis_y",
                                   "yaxis_z", "zaxis_x", "zaxis_y", "zaxis_z", "degenerate"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint round_q(longint p);
    return (p + HALF) >>> FB;
  endfunction

  function automatic logic [63:0] mag64(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint dot_q(longint a[3], longint b[3]);
    return round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
  endfunction

  // Scales the vector into the element range, then divides by the integer length.
  function automatic bit to_unit(longint c[3], output longint o[3]);
    logic [63:0] m, s, n, q;
    longint t[3];
    int k;
    m = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) if (mag64(c[i]) > m) m = mag64(c[i]);
    while (k < 63 && (m >> k) >= (64'd1 << (EW - 1))) k++;
    for (int i = 0; i < 3; i++) begin
      t[i] = c[i] >>> k;
      s = s + 64'(t[i] * t[i]);
    end
    if (s == 0) begin
      o = '{0, 0, 0};
      return 1'b1;
    end
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      longint v;
      q = ((mag64(t[i]) << FB) + (n >> 1)) / n;
      v = longint'(q);
      if (t[i] < 0) v = -v;
      o[i] = v > EMAX ? EMAX : (v < EMIN ? EMIN : v);
    end
    return 1'b0;
  endfunction

  function automatic basis_t orthonormalise(elem_t e[9]);
    longint x[3], y[3], z[3], uy[3], uz[3], ux[3], r[3];
    longint d, dy, dz;
    basis_t res;
    bit deg;
    for (int i = 0; i < 3; i++) begin
      x[i] = e[i];
      y[i] = e[3 + i];
      z[i] = e[6 + i];
    end
    deg = to_unit(y, uy);
    d = dot_q(z, uy);
    for (int i = 0; i < 3; i++) r[i] = z[i] - round_q(d * uy[i]);
    deg |= to_unit(r, uz);
    // Both projections of x are taken from the original x.
    dy = dot_q(x, uy);
    dz = dot_q(x, uz);
    for (int i = 0; i < 3; i++) r[i] = x[i] - round_q(dy * uy[i]) - round_q(dz * uz[i]);
    deg |= to_unit(r, ux);
    for (int i = 0; i < 3; i++) begin
      res.e[i] = elem_t'(ux[i]);
      res.e[3 + i] = elem_t'(uy[i]);
      res.e[6 + i] = elem_t'(uz[i]);
    end
    res.deg = deg;
    return res;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
  endtask

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_bases.push_back(cur_typed ? cur_want : orthonormalise(in_e));
      beats_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bases.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        basis_t w;
        w = expected_bases.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_e[i] !== w.e[i]) report_mismatch(FIELD_NAMES[i], out_e[i], w.e[i]);
        if (degenerate_o !== w.deg) report_mismatch(FIELD_NAMES[9], degenerate_o, w.deg);
        if (w.deg) degenerate_seen++;
      end
      beats_out++;
    end
    if (rst_ni && !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles without a beat", IDLE_LIMIT);
      $display("tb_orthonormalise_3x3_basis: done, errors");
      $finish;
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int seen, hold;
    seen = 0;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic elem_t rand_elem(int mode);
    case (mode)
      0, 1, 2: return elem_t'($urandom);
      3: return elem_t'($signed($urandom_range(2097152)) - 1048576);
      4: begin
        case ($urandom_range(4))
          0: return elem_t'(EMAX);
          1: return elem_t'(EMIN);
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return elem_t'($signed($urandom_range(65535)) - 32768);
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int mode, p, s;
    mode = $urandom_range(9);
    row.typed = 1'b0;
    for (int i = 0; i < 9; i++) row.e[i] = rand_elem(mode <= 4 ? mode : 3);
    if (mode >= 5 && mode <= 7) begin
      // Near-orthonormal: signed unit axes on a permutation plus small noise; mode 7 makes them 1.5 units long.
      p = $urandom_range(2);
      for (int a = 0; a < 3; a++) begin
        s = $urandom_range(1) ? 1 : -1;
        row.e[a * 3 + (a + p) % 3] = elem_t'(s * ONE + ($signed($urandom_range(255)) - 128));
        if (mode == 7) row.e[a * 3 + (a + p) % 3] = elem_t'(s * ONE * 3 / 2);
      end
    end else if (mode == 8) begin
      // Dependent axes: z along y, sometimes with one lsb of noise; x parts may be y minus z.
      for (int i = 0; i < 3; i++) begin
        row.e[6 + i] = row.e[3 + i] * 2 + ($urandom_range(3) == 0 ? 1 : 0);
        if ($urandom_range(1)) row.e[i] = row.e[3 + i] - row.e[6 + i];
      end
    end else if (mode == 9) begin
      // One whole axis of zero length.
      p = $urandom_range(2);
      for (int i = 0; i < 3; i++) row.e[p * 3 + i] = 0;
    end
    return row;
  endfunction

  task automatic send_row(stim_row_t row);
    in_e = row.e;
    cur_typed = row.typed;
    cur_want = row.want;
    in_valid_i = 1'b1;
    do @(negedge clk_i); while (!in_fire);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_bases.size() != 0) @(negedge clk_i);
  endtask

  function automatic stim_row_t make_row(longint v[9]);
    stim_row_t row;
    row.typed = 1'b0;
    for (int i = 0; i < 9; i++) row.e[i] = elem_t'(v[i]);
    row.want.deg = 1'b0;
    row.want.e = row.e;
    return row;
  endfunction

  stim_row_t directed[$];

  initial begin
    stim_row_t row;
    longint q;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cur_typed = 1'b0;
    for (int i = 0; i < 9; i++) in_e[i] = '0;
    cur_want.deg = 1'b0;
    cur_want.e = in_e;
    q = ONE / 4;

    // The identity comes back unchanged; the zero matrix is all zeros and degenerate.
    row = make_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    row.typed = 1'b1;
    directed.push_back(row);
    row = make_row('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    row.typed = 1'b1;
    row.want.deg = 1'b1;
    directed.push_back(row);
    directed.push_back(make_row('{EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX}));
    directed.push_back(make_row('{EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN}));
    directed.push_back(make_row('{EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX}));
    directed.push_back(make_row('{ONE, 0, 0, 0, 0, 0, 0, 0, ONE}));
    directed.push_back(make_row('{ONE, 0, 0, q, 2 * q, 3 * q, q, 2 * q, 3 * q}));
    directed.push_back(make_row('{4 * q, 2 * q, 3 * q, 3 * q, q, 0, q, q, 3 * q}));
    directed.push_back(make_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
    directed.push_back(make_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
    directed.push_back(make_row('{0, ONE, 0, EMIN, 0, 0, 0, 0, EMIN}));
    directed.push_back(make_row('{EMAX, EMAX, 0, 0, EMAX, EMAX, EMAX, 0, EMAX}));
    directed.push_back(make_row('{ONE, ONE, 0, -1, -1, -1, 0, ONE, ONE}));
    directed.push_back(make_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
    directed.push_back(make_row('{EMAX, 0, 0, 0, EMIN, 0, 0, 0, 1}));
    foreach (directed[i]) begin
      directed[i].want.e = directed[i].typed ? directed[i].e : directed[i].e;
      if (directed[i].want.deg) for (int j = 0; j < 9; j++) directed[i].want.e[j] = 0;
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_row(directed[i]);
    drain();

    // Phases: no idling after a long output hold-off, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 18 : 0;
      if (ph == 0) hold_seq++;
      for (int n = 0; n < N_RANDOM / 4; n++) send_row(random_row());
      drain();
    end

    repeat (300) @(negedge clk_i);
    $display("Covered %0d matrices (%0d typed directed rows, %0d degenerate results)",
             beats_in, 2, degenerate_seen);
    $display("over four idling phases and one long output hold-off; %0d results checked",
             beats_out);
    if (errors == 0 && expected_bases.size() == 0) begin
      $display("tb_orthonormalise_3x3_basis: done, clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_bases.size());
      $display("tb_orthonormalise_3x3_basis: done, errors");
    end
    $finish;
  end
endmodule

### files.f
+incdir+src
src/orth3_pkg.sv
src/orth3_lane.sv
src/orth3_merge.sv
src/orthonormalise_3x3_basis.sv
test/tb_orthonormalise_3x3_basis.sv
